// ----- rtl/pjq_pkg.sv -----
// Package for the priority job queue: request/response structs, opcodes,
// status codes and sequencer states. No dependencies.
`timescale 1ns / 1ps

package pjq_pkg;

    localparam int PRIO_W      = 8;
    localparam int JOB_COUNT_W = 5;
    localparam int HEAD_ID_W   = 16;

    // Opcodes
    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_FINISH = 2'd1;
    localparam logic [1:0] OP_SORT   = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [PRIO_W-1:0] priority_req;
    } t_job_req;

    typedef struct packed {
        logic [1:0]             status;
        logic [JOB_COUNT_W-1:0] job_count;
        logic                   head_valid;
        logic [PRIO_W-1:0]      head_priority;
        logic [HEAD_ID_W-1:0]   head_id;
    } t_job_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HEAD_RD,
        S_HEAD_CAP,
        S_PASS_START,
        S_PASS_LOAD,
        S_PASS_CMP,
        S_PASS_END
    } t_state;

endpackage

// ----- rtl/priority_job_queue_core.sv -----
// Priority job queue top level: circular job buffer in a memory, one shared
// compare unit driven by a bubble-pass sequencer. Depends on pjq_pkg.
`timescale 1ns / 1ps

// Usage:
//   Requests (opcode, priority_req) come in on i_valid/o_ready; every request
//   gives exactly one response (status, job_count, head job) on o_valid/i_ready.
//   o_ready is high only while the sequencer is idle; one request is worked on
//   at a time.
// Sequencing:
//   Add, finish and unused opcodes: after the request transfer come the head
//   read and the head capture, which registers the response; a new request
//   can transfer only once the sequencer is back in idle.
//   Sort of n jobs: bubble passes through the single compare unit; a pass over
//   L jobs runs start, load, the compares and end; L runs from n down to 2, and
//   sorting stops early after a pass with no swap. Head read and head capture
//   then build the response.
// The memory port (one write, one registered read per cycle) and the single
// comparator pace this work.
// Reset: clears count, head/tail pointers, id counter and response valid. The
// job memory is not cleared; only data read from slots holding live jobs is used.
// Stall: a response waits in the output register; the sequencer holds its last
// state until the response register is free.
module priority_job_queue_core #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  pjq_pkg::t_job_req  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output pjq_pkg::t_job_rsp  o_data
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW = pjq_pkg::PRIO_W + ID_BITS;

    // Circular pointer increment with wrap at the depth
    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        ptr_inc = (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Shared compare unit: true if job a must stand before job b
    function automatic logic goes_first(input logic [EW-1:0] a, input logic [EW-1:0] b);
        logic [pjq_pkg::PRIO_W-1:0] pa;
        logic [pjq_pkg::PRIO_W-1:0] pb;
        pa = a[EW-1 -: pjq_pkg::PRIO_W];
        pb = b[EW-1 -: pjq_pkg::PRIO_W];
        if (pa != pb) begin
            goes_first = pa > pb;
        end else begin
            goes_first = a[ID_BITS-1:0] < b[ID_BITS-1:0];
        end
    endfunction

    // Job memory
    logic [EW-1:0] mem [QUEUE_DEPTH];
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [EW-1:0] mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [EW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= mem[mem_raddr];
    end

    // Control and datapath registers
    pjq_pkg::t_state   r_state, n_state;
    logic [AW-1:0]     r_head, n_head;
    logic [AW-1:0]     r_tail, n_tail;
    logic [CW-1:0]     r_count, n_count;
    logic [ID_BITS-1:0] r_next_id, n_next_id;
    logic [1:0]        r_status, n_status;
    logic [EW-1:0]     r_carry, n_carry;
    logic [AW-1:0]     r_pos, n_pos;
    logic [CW-1:0]     r_left, n_left;
    logic [CW-1:0]     r_pass_len, n_pass_len;
    logic              r_swapped, n_swapped;
    logic              r_o_valid, n_o_valid;
    pjq_pkg::t_job_rsp r_o_data, n_o_data;

    logic [AW-1:0] pos_nx;
    logic          x_first;
    logic          out_free;

    assign pos_nx   = ptr_inc(r_pos);
    assign x_first  = goes_first(r_rd_data, r_carry);
    assign out_free = !r_o_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= pjq_pkg::S_IDLE;
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= '0;
            r_next_id <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_count   <= n_count;
            r_next_id <= n_next_id;
            r_o_valid <= n_o_valid;
        end
    end

    // Payload and sequencer work registers
    always_ff @(posedge i_clk) begin
        r_status   <= n_status;
        r_carry    <= n_carry;
        r_pos      <= n_pos;
        r_left     <= n_left;
        r_pass_len <= n_pass_len;
        r_swapped  <= n_swapped;
        r_o_data   <= n_o_data;
    end

    // Next state and outputs
    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_tail     = r_tail;
        n_count    = r_count;
        n_next_id  = r_next_id;
        n_status   = r_status;
        n_carry    = r_carry;
        n_pos      = r_pos;
        n_left     = r_left;
        n_pass_len = r_pass_len;
        n_swapped  = r_swapped;
        n_o_data   = r_o_data;
        n_o_valid  = r_o_valid && !i_ready;
        mem_we     = 1'b0;
        mem_waddr  = r_pos;
        mem_wdata  = r_carry;
        mem_raddr  = r_head;
        o_ready    = 1'b0;

        case (r_state)
            pjq_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_status = pjq_pkg::ST_OK;
                    n_state  = pjq_pkg::S_HEAD_RD;
                    case (i_data.opcode)
                        pjq_pkg::OP_ADD: begin
                            if (r_count == CW'(QUEUE_DEPTH)) begin
                                n_status = pjq_pkg::ST_FULL;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = r_tail;
                                mem_wdata = {i_data.priority_req, r_next_id};
                                n_tail    = ptr_inc(r_tail);
                                n_count   = r_count + 1'b1;
                                n_next_id = r_next_id + 1'b1;
                            end
                        end
                        pjq_pkg::OP_FINISH: begin
                            if (r_count == '0) begin
                                n_status = pjq_pkg::ST_EMPTY;
                            end else begin
                                n_head  = ptr_inc(r_head);
                                n_count = r_count - 1'b1;
                            end
                        end
                        pjq_pkg::OP_SORT: begin
                            if (r_count > CW'(1)) begin
                                n_pass_len = r_count;
                                n_state    = pjq_pkg::S_PASS_START;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // Read the head slot; data is registered next cycle
            pjq_pkg::S_HEAD_RD: begin
                mem_raddr = r_head;
                n_state   = pjq_pkg::S_HEAD_CAP;
            end

            // Build the response once the output register is free
            pjq_pkg::S_HEAD_CAP: begin
                mem_raddr = r_head;
                if (out_free) begin
                    n_o_valid            = 1'b1;
                    n_o_data.status      = r_status;
                    n_o_data.job_count   = pjq_pkg::JOB_COUNT_W'(r_count);
                    if (r_count != '0) begin
                        n_o_data.head_valid    = 1'b1;
                        n_o_data.head_priority = r_rd_data[EW-1 -: pjq_pkg::PRIO_W];
                        n_o_data.head_id       =
                            pjq_pkg::HEAD_ID_W'(r_rd_data[ID_BITS-1:0]);
                    end else begin
                        n_o_data.head_valid    = 1'b0;
                        n_o_data.head_priority = '0;
                        n_o_data.head_id       = '0;
                    end
                    n_state = pjq_pkg::S_IDLE;
                end
            end

            // New bubble pass starts at the head
            pjq_pkg::S_PASS_START: begin
                mem_raddr = r_head;
                n_pos     = r_head;
                n_left    = r_pass_len - 1'b1;
                n_swapped = 1'b0;
                n_state   = pjq_pkg::S_PASS_LOAD;
            end

            // Head job becomes the carry; fetch its neighbor
            pjq_pkg::S_PASS_LOAD: begin
                n_carry   = r_rd_data;
                mem_raddr = pos_nx;
                n_state   = pjq_pkg::S_PASS_CMP;
            end

            // One compare per cycle: the job that goes first lands at r_pos
            pjq_pkg::S_PASS_CMP: begin
                mem_we    = 1'b1;
                mem_waddr = r_pos;
                if (x_first) begin
                    mem_wdata = r_rd_data;
                    n_swapped = 1'b1;
                end else begin
                    mem_wdata = r_carry;
                    n_carry   = r_rd_data;
                end
                n_pos     = pos_nx;
                mem_raddr = ptr_inc(pos_nx);
                n_left    = r_left - 1'b1;
                if (r_left == CW'(1)) begin
                    n_state = pjq_pkg::S_PASS_END;
                end
            end

            // Carry settles at the end of the pass
            pjq_pkg::S_PASS_END: begin
                mem_we     = 1'b1;
                mem_waddr  = r_pos;
                mem_wdata  = r_carry;
                n_pass_len = r_pass_len - 1'b1;
                if (r_swapped && (r_pass_len > CW'(2))) begin
                    n_state = pjq_pkg::S_PASS_START;
                end else begin
                    n_state = pjq_pkg::S_HEAD_RD;
                end
            end

            default: begin
                n_state = pjq_pkg::S_IDLE;
            end
        endcase
    end

    assign o_valid = r_o_valid;
    assign o_data  = r_o_data;

endmodule
